// ===== hdl/key_index_pair_sorter_assert.svh =====
// Assertion macros used by the sorter module.
// Depends on nothing; included inside module bodies.
`ifndef KEY_INDEX_PAIR_SORTER_ASSERT_SVH
`define KEY_INDEX_PAIR_SORTER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define KIPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define KIPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/kips_pkg.sv =====
// Shared types and constants for the key/index pair sorter.
// No dependencies.
`default_nettype none
package kips_pkg;
    localparam int KEY_W = 32;
    localparam int ID_W  = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_OUT_RD,
        ST_OUT_EMIT
    } kips_state_t;
endpackage
`default_nettype wire

// ===== hdl/kips_mem.sv =====
// Synchronous one-write one-read pair store (key and id side by side).
// Depends on kips_pkg.
`default_nettype none
module kips_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [kips_pkg::KEY_W-1:0] wkey,
    input  wire logic [kips_pkg::ID_W-1:0]  wid,
    input  wire logic [AW-1:0]            raddr,
    output logic      [kips_pkg::KEY_W-1:0] rkey,
    output logic      [kips_pkg::ID_W-1:0]  rid
);
    import kips_pkg::*;

    logic [KEY_W+ID_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wkey, wid};
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        {rkey, rid} <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/key_index_pair_sorter.sv =====
// Key/index pair sorter: insertion sort over one synchronous memory.
// Depends on kips_pkg, kips_mem and key_index_pair_sorter_assert.svh.
//
// Usage:
// - Input transaction: key, sample_id, last are taken at a clock edge with
//   start high and busy low.
// - Each pair is inserted in order: the stored pairs with a larger key are
//   moved up one entry at a time, each move a memory read then a write.
//   At most CAPACITY-1 pairs are moved for one item. A pair arriving at a
//   full store is dropped and sets the drop flag.
// - On a pair with last set, all stored pairs are then emitted in
//   ascending signed key order, ties in arrival order, each result read
//   and then shown: result ports are valid for one cycle while strobe is
//   high; last_out marks the final one, overflow is set on every result if
//   any pair of the set was dropped.
// - busy stays high through insertion and output; the store then empties.
// - The receiver cannot stall: results are never held back.
// - Reset clears the fill count and the drop flag; no memory clearing.
`default_nettype none
module key_index_pair_sorter #(
    parameter int CAPACITY = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [kips_pkg::KEY_W-1:0] key,
    input  wire logic        [kips_pkg::ID_W-1:0]  sample_id,
    input  wire logic                        last,
    output logic                             strobe,
    output logic signed [kips_pkg::KEY_W-1:0] sorted_key,
    output logic        [kips_pkg::ID_W-1:0]  sorted_id,
    output logic                             last_out,
    output logic                             overflow
);
    import kips_pkg::*;
    `include "key_index_pair_sorter_assert.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    kips_state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          drop_reg, drop_next;
    logic          last_reg, last_next;
    logic [KEY_W-1:0] nkey_reg, nkey_next;
    logic [ID_W-1:0]  nid_reg, nid_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [KEY_W-1:0] wkey, rkey;
    logic [ID_W-1:0]  wid, rid;

    kips_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wkey(wkey), .wid(wid),
        .raddr(raddr), .rkey(rkey), .rid(rid)
    );

    logic take;
    logic larger;
    assign take   = start && (state_reg == ST_IDLE);
    // stored key strictly larger than new key (signed)
    assign larger = $signed(rkey) > $signed(nkey_reg);

    // next state and datapath registers
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        drop_next  = drop_reg;
        last_next  = last_reg;
        nkey_next  = nkey_reg;
        nid_next   = nid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    nkey_next = key;
                    nid_next  = sample_id;
                    last_next = last;
                    pos_next  = fill_reg;
                    if (fill_reg == CAP_C)
                    begin
                        drop_next = 1'b1;
                        if (last)
                        begin
                            pos_next   = '0;
                            state_next = ST_OUT_RD;
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                if (larger)
                begin
                    pos_next   = pos_reg - 1'b1;
                    state_next = (pos_reg == CW'(1)) ? ST_PLACE : ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                fill_next = fill_reg + 1'b1;
                if (last_reg)
                begin
                    pos_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg + 1'b1 == fill_reg)
                begin
                    fill_next  = '0;
                    drop_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory port and output control
    always_comb
    begin
        we     = 1'b0;
        waddr  = pos_reg[AW-1:0];
        wkey   = nkey_reg;
        wid    = nid_reg;
        raddr  = pos_reg[AW-1:0];
        strobe = 1'b0;
        unique case (state_reg)
            ST_SHIFT_RD:
            begin
                raddr = AW'(pos_reg - 1'b1);
            end
            ST_SHIFT_WR:
            begin
                we   = larger;
                wkey = rkey;
                wid  = rid;
            end
            ST_PLACE:
            begin
                we = 1'b1;
            end
            ST_OUT_EMIT:
            begin
                strobe = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign sorted_key = rkey;
    assign sorted_id  = rid;
    assign last_out   = strobe && (pos_reg + 1'b1 == fill_reg);
    assign overflow   = drop_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            pos_reg   <= '0;
            drop_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            drop_reg  <= drop_next;
            last_reg  <= last_next;
        end
    end

    // pending pair
    always_ff @(posedge clk)
    begin
        nkey_reg <= nkey_next;
        nid_reg  <= nid_next;
    end

    `KIPS_ASSERT_IMP(a_fill_range, clk, rst_n, 1'b1, fill_reg <= CAP_C, "fill count over capacity")
    `KIPS_ASSERT_IMP(a_emit_in_range, clk, rst_n, strobe, pos_reg < fill_reg, "emit past fill")
    `KIPS_ASSERT_NXT(a_last_empties, clk, rst_n, last_out, fill_reg == '0 && !drop_reg, "store not emptied")
    `KIPS_ASSERT_IMP(a_place_room, clk, rst_n, state_reg == ST_PLACE, fill_reg < CAP_C, "place into full store")
endmodule
`default_nettype wire
